>>> rtl/cle_pkg.sv
// shared types, constants and command/status structs for the console line echo engine
// no dependencies; imported by cle_ctrl, cle_datapath, console_line_echo_engine, the checker and the testbench
package cle_pkg;

   localparam int RING_DEPTH_DEF = 128;

   localparam logic [7:0] DELIM_RESET = 8'h0D;
   localparam logic [7:0] DEL_BYTE    = 8'h7F;
   localparam logic [7:0] CR_BYTE     = 8'h0D;
   localparam logic [7:0] LF_BYTE     = 8'h0A;
   localparam logic [7:0] ESC_BYTE    = 8'h1B;

   localparam logic KIND_HOST = 1'b0;
   localparam logic KIND_READ = 1'b1;
   localparam logic SRC_ECHO  = 1'b0;
   localparam logic SRC_READ  = 1'b1;

   // cursor left one column, then clear to end of line
   localparam int ERASE_LEN  = 7;
   localparam int EMIT_IDX_W = $clog2(ERASE_LEN);
   localparam logic [7:0] ERASE_SEQ [ERASE_LEN] =
      '{ESC_BYTE, 8'h5B, 8'h31, 8'h44, ESC_BYTE, 8'h5B, 8'h4B};
   localparam logic [EMIT_IDX_W-1:0] ERASE_LAST = EMIT_IDX_W'(ERASE_LEN - 1);

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_SILENT,
      ACT_ECHO,
      ACT_CR,
      ACT_ERASE,
      ACT_POP,
      ACT_EMPTY
   } act_type;

   typedef struct packed {
      logic take_item;
      logic take_csr;
      logic fix_delim;
      logic scan;
      logic load_out;
   } cle_cmd_type;

   typedef struct packed {
      act_type action;
      logic    out_free;
      logic    emit_last;
      logic    scan_done;
   } cle_status_type;

endpackage

>>> rtl/cle_ctrl.sv
// controller state machine for the console line echo engine
// depends on cle_pkg; drives cle_datapath through cle_cmd_type
module cle_ctrl
   import cle_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  cle_status_type status,
   output cle_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_FIX  = 4'b0010,
      S_EMIT = 4'b0100,
      S_SCAN = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      csr_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            csr_ready = !req_valid;
            if (req_valid) begin
               cmd.take_item = 1'b1;
               if (status.action inside {ACT_NONE, ACT_SILENT}) begin
                  state_in = S_IDLE;
               end else if (status.action inside {ACT_POP, ACT_ERASE}) begin
                  state_in = S_FIX;
               end else begin
                  state_in = S_EMIT;
               end
            end else if (csr_valid) begin
               cmd.take_csr = 1'b1;
               state_in     = S_SCAN;
            end
         end
         S_FIX: begin
            // popped or erased byte now out of the memory
            cmd.fix_delim = 1'b1;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (status.emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_one_transaction: assert property (@(posedge clock) disable iff (reset)
      !(cmd.take_item && cmd.take_csr))
      else $error("item and csr write taken together");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && cmd.load_out && status.emit_last) |=> (state_ff == S_IDLE))
      else $error("controller did not return to idle after last result");

   a_fix_then_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.fix_delim |=> (state_ff == S_EMIT))
      else $error("delimiter fix not followed by emit");
`endif

endmodule

>>> rtl/cle_datapath.sv
// receive ring, counters, delimiter register and output stage of the echo engine
// depends on cle_pkg; steered by cle_ctrl through cle_cmd_type
module cle_datapath
   import cle_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_kind,
   input  logic [7:0]     req_data,
   input  logic [7:0]     csr_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic           rsp_source,
   output logic [7:0]     rsp_out_byte,
   output logic           rsp_read_empty,
   output logic           rsp_line_ready,
   output logic           rsp_last,
   input  cle_cmd_type    cmd,
   output cle_status_type status
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam logic [PTR_W:0] DEPTH_P = (PTR_W + 1)'(RING_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RING_DEPTH);

   // both operands stay below the depth, so one subtract wraps the sum
   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] offs);
      logic [PTR_W:0] sum;
      sum = (PTR_W + 1)'(base) + (PTR_W + 1)'(offs);
      if (sum >= DEPTH_P) begin
         sum = sum - DEPTH_P;
      end
      return sum[PTR_W-1:0];
   endfunction

   logic [7:0]            ring_mem [RING_DEPTH];
   logic [7:0]            rd_data_ff;
   logic                  mem_we, mem_re;
   logic [PTR_W-1:0]      mem_addr;

   logic [PTR_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      delim_cnt_ff, delim_cnt_in;
   logic [7:0]            delimiter_ff, delimiter_in;
   logic [CNT_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                  scan_pend_ff, scan_pend_in;
   act_type               act_ff, act_in;
   logic [EMIT_IDX_W-1:0] emit_idx_ff, emit_idx_in;
   logic [7:0]            item_data_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_source_ff, rsp_read_empty_ff, rsp_line_ready_ff, rsp_last_ff;
   logic [7:0]            rsp_out_byte_ff;

   logic                  ring_full, ring_empty, scan_more;
   act_type               act_now;
   logic                  e_source, e_empty, e_last;
   logic [7:0]            e_byte;

   assign ring_full  = (count_ff == DEPTH_C);
   assign ring_empty = (count_ff == '0);
   assign scan_more  = (scan_idx_ff != count_ff);

   // classify the byte on the request ports against the present ring state
   always_comb begin
      act_now = ACT_NONE;
      if (req_kind == KIND_READ) begin
         act_now = ring_empty ? ACT_EMPTY : ACT_POP;
      end else if (req_data == DEL_BYTE) begin
         act_now = ring_empty ? ACT_NONE : ACT_ERASE;
      end else if (req_data inside {[8'h20:8'h7E]}) begin
         act_now = ring_full ? ACT_NONE : ACT_ECHO;
      end else if (req_data inside {[8'h80:8'hFF]}) begin
         act_now = ring_full ? ACT_NONE : ACT_SILENT;
      end else if (req_data == CR_BYTE) begin
         act_now = ring_full ? ACT_NONE : ACT_CR;
      end
   end

   // result item for the current emit index
   always_comb begin
      e_source = SRC_ECHO;
      e_byte   = 8'h00;
      e_empty  = 1'b0;
      e_last   = 1'b1;
      case (act_ff)
         ACT_ECHO: begin
            e_byte = item_data_ff;
         end
         ACT_CR: begin
            e_byte = (emit_idx_ff == '0) ? LF_BYTE : CR_BYTE;
            e_last = (emit_idx_ff != '0);
         end
         ACT_ERASE: begin
            e_byte = ERASE_SEQ[emit_idx_ff];
            e_last = (emit_idx_ff == ERASE_LAST);
         end
         ACT_POP: begin
            e_source = SRC_READ;
            e_byte   = rd_data_ff;
         end
         ACT_EMPTY: begin
            e_source = SRC_READ;
            e_empty  = 1'b1;
         end
         default: begin
            e_last = 1'b1;
         end
      endcase
   end

   // memory port steering
   always_comb begin
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      mem_addr = head_ff;
      if (cmd.take_item) begin
         if (act_now inside {ACT_SILENT, ACT_ECHO, ACT_CR}) begin
            mem_we   = 1'b1;
            mem_addr = wrap_add(head_ff, count_ff);
         end else if (act_now == ACT_POP) begin
            mem_re   = 1'b1;
            mem_addr = head_ff;
         end else if (act_now == ACT_ERASE) begin
            mem_re   = 1'b1;
            mem_addr = wrap_add(head_ff, count_ff - CNT_W'(1));
         end
      end else if (cmd.scan && scan_more) begin
         mem_re   = 1'b1;
         mem_addr = wrap_add(head_ff, scan_idx_ff);
      end
   end

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      delim_cnt_in = delim_cnt_ff;
      delimiter_in = delimiter_ff;
      scan_idx_in  = scan_idx_ff;
      scan_pend_in = scan_pend_ff;
      act_in       = act_ff;
      emit_idx_in  = emit_idx_ff;
      if (cmd.take_item) begin
         act_in      = act_now;
         emit_idx_in = '0;
         if (act_now inside {ACT_SILENT, ACT_ECHO, ACT_CR}) begin
            count_in = count_ff + CNT_W'(1);
            if (req_data == delimiter_ff) begin
               delim_cnt_in = delim_cnt_ff + CNT_W'(1);
            end
         end else if (act_now == ACT_POP) begin
            head_in  = wrap_add(head_ff, CNT_W'(1));
            count_in = count_ff - CNT_W'(1);
         end else if (act_now == ACT_ERASE) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
      if (cmd.fix_delim && rd_data_ff == delimiter_ff && delim_cnt_ff != '0) begin
         delim_cnt_in = delim_cnt_ff - CNT_W'(1);
      end
      if (cmd.take_csr) begin
         delimiter_in = csr_data;
         delim_cnt_in = '0;
         scan_idx_in  = '0;
         scan_pend_in = 1'b0;
      end
      // recount: each ring read is registered and compared with the delimiter in the next cycle
      if (cmd.scan) begin
         scan_pend_in = scan_more;
         if (scan_more) begin
            scan_idx_in = scan_idx_ff + CNT_W'(1);
         end
         if (scan_pend_ff && rd_data_ff == delimiter_ff) begin
            delim_cnt_in = delim_cnt_ff + CNT_W'(1);
         end
      end
      if (cmd.load_out) begin
         emit_idx_in = emit_idx_ff + EMIT_IDX_W'(1);
      end
   end

   assign rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_addr] <= req_data;
      end
      if (mem_re) begin
         rd_data_ff <= ring_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         delim_cnt_ff <= '0;
         delimiter_ff <= DELIM_RESET;
         scan_idx_ff  <= '0;
         scan_pend_ff <= 1'b0;
         act_ff       <= ACT_NONE;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         delim_cnt_ff <= delim_cnt_in;
         delimiter_ff <= delimiter_in;
         scan_idx_ff  <= scan_idx_in;
         scan_pend_ff <= scan_pend_in;
         act_ff       <= act_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         item_data_ff <= req_data;
      end
      if (cmd.load_out) begin
         rsp_source_ff     <= e_source;
         rsp_out_byte_ff   <= e_byte;
         rsp_read_empty_ff <= e_empty;
         rsp_line_ready_ff <= (delim_cnt_ff != '0);
         rsp_last_ff       <= e_last;
      end
   end

   assign status.action    = act_now;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign status.emit_last = e_last;
   assign status.scan_done = !scan_more && !scan_pend_ff;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_source     = rsp_source_ff;
   assign rsp_out_byte   = rsp_out_byte_ff;
   assign rsp_read_empty = rsp_read_empty_ff;
   assign rsp_line_ready = rsp_line_ready_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("ring count beyond depth");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("output stage overwritten before transaction");

   a_store_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.take_item && act_now == ACT_ECHO) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("stored byte not counted");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> (scan_idx_ff <= count_ff))
      else $error("recount ran past ring contents");
`endif

endmodule

>>> rtl/console_line_echo_engine.sv
// Console line echo engine: terminal input line discipline with a receive ring of RING_DEPTH
// bytes and echo. A host byte (req_kind 0) is accepted while idle; a printable byte then
// gives its echo, carriage return gives two results (LF, then CR), a high byte is stored
// silently, and DEL waits for the registered ring memory read before its seven erase bytes,
// one per cycle while the output is free. A read request (req_kind 1) on an empty ring
// gives its empty result directly, otherwise it too waits for the registered memory read.
// The single output register sets the pace of one result per cycle while rsp_ready keeps it
// free; the next transaction is accepted while the last result still waits there. A write
// on the csr_ port recounts the delimiter bytes held, reading one ring entry per cycle, and
// occupies the block until the recount is done.
// Ring contents are not cleared at reset; only written entries are ever read.
module console_line_echo_engine
   import cle_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_source,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_read_empty,
   output logic       rsp_line_ready,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   cle_cmd_type    cmd;
   cle_status_type status;

   cle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cle_datapath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_kind       (req_kind),
      .req_data       (req_data),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_source     (rsp_source),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_read_empty (rsp_read_empty),
      .rsp_line_ready (rsp_line_ready),
      .rsp_last       (rsp_last),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

>>> verif/console_line_echo_engine_checker.sv
// result checker for the console line echo engine: watches the request, csr and response
// channels, keeps its own copy of the receive ring and line state, and compares every response
// depends on cle_pkg for the kind, source and control byte constants
module console_line_echo_engine_checker
   import cle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_source,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_read_empty,
   input  logic       rsp_line_ready,
   input  logic       rsp_last,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [7:0] csr_data,
   output int         mismatches,
   output int         awaited
);

   localparam int DEPTH = RING_DEPTH_DEF;

   // cursor left, then clear to end of line
   localparam logic [7:0] ERASE_ECHO [7] =
      '{8'h1B, 8'h5B, 8'h31, 8'h44, 8'h1B, 8'h5B, 8'h4B};

   typedef struct packed {
      logic       source;
      logic [7:0] out_byte;
      logic       read_empty;
      logic       line_ready;
      logic       last;
   } echo_result_t;

   logic [7:0]   ring [DEPTH];
   int           ring_head;
   int           ring_fill;
   int           delim_hits;
   logic [7:0]   delimiter;
   echo_result_t owed_out [$];
   int           bad_fields = 0;
   int           owed_count = 0;

   assign mismatches = bad_fields;
   assign awaited    = owed_count;

   task automatic owe(input logic src, input logic [7:0] b, input logic empty, input logic fin);
      echo_result_t r;
      r.source     = src;
      r.out_byte   = b;
      r.read_empty = empty;
      r.line_ready = (delim_hits != 0);
      r.last       = fin;
      owed_out.push_back(r);
   endtask

   task automatic rewrite_delimiter(input logic [7:0] value);
      delimiter  = value;
      delim_hits = 0;
      for (int i = 0; i < ring_fill; i++) begin
         if (ring[(ring_head + i) % DEPTH] == delimiter) delim_hits++;
      end
   endtask

   task automatic line_discipline_step(input logic kind, input logic [7:0] data);
      logic [7:0] taken;
      if (kind == KIND_READ) begin
         if (ring_fill == 0) begin
            owe(SRC_READ, 8'h00, 1'b1, 1'b1);
         end else begin
            taken     = ring[ring_head];
            ring_head = (ring_head + 1) % DEPTH;
            ring_fill--;
            if (taken == delimiter && delim_hits != 0) delim_hits--;
            owe(SRC_READ, taken, 1'b0, 1'b1);
         end
      end else if (data == DEL_BYTE) begin
         // erase on an empty ring does nothing at all
         if (ring_fill != 0) begin
            ring_fill--;
            taken = ring[(ring_head + ring_fill) % DEPTH];
            if (taken == delimiter && delim_hits != 0) delim_hits--;
            for (int k = 0; k < 7; k++) owe(SRC_ECHO, ERASE_ECHO[k], 1'b0, k == 6);
         end
      end else if (data >= 8'h20 || data == CR_BYTE) begin
         // a full ring drops the byte without echo
         if (ring_fill < DEPTH) begin
            ring[(ring_head + ring_fill) % DEPTH] = data;
            ring_fill++;
            if (data == delimiter) delim_hits++;
            if (data == CR_BYTE) begin
               owe(SRC_ECHO, LF_BYTE, 1'b0, 1'b0);
               owe(SRC_ECHO, CR_BYTE, 1'b0, 1'b1);
            end else if (data < 8'h80) begin
               owe(SRC_ECHO, data, 1'b0, 1'b1);
            end
         end
      end
   endtask

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         bad_fields++;
      end
   endtask

   always @(posedge clock) begin
      echo_result_t want;
      if (reset) begin
         ring_head  = 0;
         ring_fill  = 0;
         delim_hits = 0;
         delimiter  = DELIM_RESET;
         owed_out.delete();
      end else begin
         // older results leave the queue before this edge's request adds new ones
         if (rsp_valid && rsp_ready) begin
            if (owed_out.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual byte %0h source %0b",
                        $time, rsp_out_byte, rsp_source);
               bad_fields++;
            end else begin
               want = owed_out.pop_front();
               check_field("source", want.source, rsp_source);
               check_field("out_byte", want.out_byte, rsp_out_byte);
               check_field("read_empty", want.read_empty, rsp_read_empty);
               check_field("line_ready", want.line_ready, rsp_line_ready);
               check_field("last", want.last, rsp_last);
            end
         end
         if (csr_valid && csr_ready) rewrite_delimiter(csr_data);
         if (req_valid && req_ready) line_discipline_step(req_kind, req_data);
      end
      owed_count <= owed_out.size();
   end

endmodule

>>> verif/console_line_echo_engine_tb.sv
// testbench top for the console line echo engine: clock, reset, request and csr stimulus,
// random response back-pressure and the final verdict
// depends on cle_pkg, console_line_echo_engine and console_line_echo_engine_checker
module console_line_echo_engine_tb;
   import cle_pkg::*;

   localparam int SETTLE      = 16;
   localparam int CYCLE_LIMIT = 500000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_kind = KIND_HOST;
   logic [7:0] req_data = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b1;
   logic       rsp_source;
   logic [7:0] rsp_out_byte;
   logic       rsp_read_empty;
   logic       rsp_line_ready;
   logic       rsp_last;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = 8'h00;

   int mismatches;
   int awaited;
   int items_sent = 0;
   int cycles = 0;
   int stall_left = 0;
   bit quiet = 1'b0;

   console_line_echo_engine dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_source     (rsp_source),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_read_empty (rsp_read_empty),
      .rsp_line_ready (rsp_line_ready),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   console_line_echo_engine_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_source     (rsp_source),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_read_empty (rsp_read_empty),
      .rsp_line_ready (rsp_line_ready),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatches     (mismatches),
      .awaited        (awaited)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // response back-pressure in random bursts
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 18);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_item(input logic kind, input logic [7:0] data);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_data  <= data;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // holds the sender until every owed result is out and the block has gone quiet
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_delimiter(input logic [7:0] value);
      drain_and_settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] host_byte();
      case ($urandom_range(0, 15))
         0, 1, 2, 3, 4, 5, 6, 7, 8: return 8'($urandom_range(8'h20, 8'h7E));
         9:                         return CR_BYTE;
         10, 11:                    return DEL_BYTE;
         12, 13:                    return 8'($urandom_range(8'h80, 8'hFF));
         14:                        return 8'($urandom_range(8'h00, 8'h1F));
         default:                   return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // a typed line with the odd rub-out, closed by carriage return, then some reads
   task automatic type_line();
      int len;
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 5) == 0) send_item(KIND_HOST, DEL_BYTE);
         else send_item(KIND_HOST, 8'($urandom_range(8'h20, 8'h7E)));
      end
      send_item(KIND_HOST, CR_BYTE);
      repeat ($urandom_range(0, len + 2)) send_item(KIND_READ, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 4)) begin
         if ($urandom_range(0, 1) == 1) send_item(KIND_READ, 8'($urandom_range(0, 255)));
         else send_item(KIND_HOST, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic mixed_traffic(input int upto, input int read_share);
      while (items_sent < upto) begin
         if ($urandom_range(0, 99) < read_share) send_item(KIND_READ, 8'($urandom_range(0, 255)));
         else send_item(KIND_HOST, host_byte());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty ring cases, ignored controls, every echo kind, pops in order
      send_item(KIND_READ, 8'h00);
      send_item(KIND_HOST, DEL_BYTE);
      send_item(KIND_HOST, 8'h00);
      send_item(KIND_HOST, 8'h1F);
      send_item(KIND_HOST, LF_BYTE);
      send_item(KIND_HOST, ESC_BYTE);
      send_item(KIND_HOST, 8'h20);
      send_item(KIND_HOST, 8'h7E);
      send_item(KIND_HOST, 8'h80);
      send_item(KIND_HOST, 8'hFF);
      send_item(KIND_HOST, CR_BYTE);
      send_item(KIND_HOST, DEL_BYTE);
      send_item(KIND_HOST, DEL_BYTE);
      send_item(KIND_HOST, CR_BYTE);
      send_item(KIND_HOST, 8'h55);
      repeat (5) send_item(KIND_READ, 8'h00);
      send_item(KIND_READ, 8'hFF);
      send_item(KIND_HOST, DEL_BYTE);

      // delimiter that can never be stored
      write_delimiter(8'h00);
      while (items_sent < 45) begin
         if ($urandom_range(0, 3) != 0) type_line();
         else send_noise();
      end

      // fill past capacity so that the ring-full drop is exercised
      write_delimiter(8'hFF);
      repeat (135) begin
         case ($urandom_range(0, 7))
            0:       send_item(KIND_HOST, 8'hFF);
            1:       send_item(KIND_HOST, 8'h41);
            2:       send_item(KIND_HOST, CR_BYTE);
            3, 4:    send_item(KIND_HOST, 8'($urandom_range(8'h20, 8'h7E)));
            default: send_item(KIND_HOST, 8'($urandom_range(8'h80, 8'hFE)));
         endcase
      end

      // recount over a full, wrapped ring
      write_delimiter(8'h41);
      mixed_traffic(items_sent + 12, 60);

      write_delimiter(DELIM_RESET);
      quiet = 1'b1;
      mixed_traffic(items_sent + 15, 50);

      drain_and_settle();
      if (mismatches == 0 && awaited == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/cle_pkg.sv
rtl/cle_ctrl.sv
rtl/cle_datapath.sv
rtl/console_line_echo_engine.sv
verif/console_line_echo_engine_checker.sv
verif/console_line_echo_engine_tb.sv
